// ===== hw/rtl/bbl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared constants, types and codes for the 3x3 box blur with edge
// replication.
// ----------------------------------------------------------------------------
package bbl_pkg;

	// Frame limits and the counter widths that follow from them.
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);

	// Configuration register widths and port sizes.
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	// Request opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Pixel and sum widths: a column sum of three samples, a window sum of nine.
	localparam int CH_W   = 8;
	localparam int NUM_CH = 3;
	localparam int PIX_W  = NUM_CH * CH_W;
	localparam int CSUM_W = 10;
	localparam int TSUM_W = 12;

	// Reciprocal of nine in 16 fractional bits; exact floor for sums up to 2295.
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

	// Job queue between the front and back parts.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

	typedef logic [NUM_CH-1:0][CSUM_W-1:0] csum_t;
	typedef logic [NUM_CH-1:0][TSUM_W-1:0] tsum_t;

	// One request's worth of output work: up to two window sums.
	typedef struct packed {
		tsum_t sum_a;
		tsum_t sum_b;
		logic  has_a;
		logic  has_b;
		logic  eof;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic [FIFO_LVL_W-1:0] level;
		logic                  not_empty;
	} fifo_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/box_blur_3x3_edge_replicate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_replicate
// 3x3 mean filter over a raster pixel stream with replicated borders.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while in_ready is high; a row-closing request
// gives two results, the second leaving the output register after the first.
// Path: a request passes the stage 1 registers, the job queue, the back part's
// job register and the output register before its result is valid.
// Reset: counters, window and drain state clear; width 640, height 480; the
// line stores are not cleared and are rewritten by the first rows of a frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_replicate (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             op,
	input  wire logic [bbl_pkg::CH_W-1:0]         blue_in,
	input  wire logic [bbl_pkg::CH_W-1:0]         green_in,
	input  wire logic [bbl_pkg::CH_W-1:0]         red_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [bbl_pkg::CH_W-1:0]              blue_out,
	output logic [bbl_pkg::CH_W-1:0]              green_out,
	output logic [bbl_pkg::CH_W-1:0]              red_out,
	output logic                                  last_of_run,
	output logic                                  end_of_frame,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bbl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                push;
	logic                pop;
	bbl_pkg::job_t       push_job;
	bbl_pkg::job_t       head_job;
	bbl_pkg::fifo_stat_t fifo_stat;

	// Front part: position tracking, line stores and window sums.
	bbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_job  (push_job)
	);

	// Job queue between the two parts.
	bbl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (fifo_stat)
	);

	// Back part: division and result delivery.
	bbl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_stat    (fifo_stat),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.blue_out     (blue_out),
		.green_out    (green_out),
		.red_out      (red_out),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/bbl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module bbl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bbl_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_front
// Accepts requests, tracks the raster position, updates the two line stores
// and the column window, and queues the window sums of each output pixel.
// ----------------------------------------------------------------------------
module bbl_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             op,
	input  wire logic [bbl_pkg::CH_W-1:0]         blue_in,
	input  wire logic [bbl_pkg::CH_W-1:0]         green_in,
	input  wire logic [bbl_pkg::CH_W-1:0]         red_in,
	input  wire logic                             cfg_wr_en,
	input  wire logic [bbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [bbl_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire bbl_pkg::fifo_stat_t              fifo_stat,
	output logic                                  push,
	output bbl_pkg::job_t                         push_job
);

	logic [bbl_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [bbl_pkg::HEIGHT_REG_W-1:0] height_q;
	logic [bbl_pkg::WIDTH_REG_W-1:0]  width_eff;
	logic [bbl_pkg::HEIGHT_REG_W-1:0] height_eff;
	logic [bbl_pkg::COL_W-1:0]        column_count_q;
	logic [bbl_pkg::ROW_W-1:0]        row_count_q;
	logic                             draining_q;
	logic [bbl_pkg::FIFO_LVL_W:0]     occupancy;
	logic                             take;
	logic                             end_row;
	logic                             last_row;
	logic                             emitting;

	logic                             valid_s1;
	logic                             drain_s1;
	logic                             row0_s1;
	logic                             first_col_s1;
	logic                             has_a_s1;
	logic                             has_b_s1;
	logic                             eof_s1;
	logic [bbl_pkg::COL_W-1:0]        col_s1;
	logic [bbl_pkg::PIX_W-1:0]        pix_s1;
	logic                             byp_s1;
	logic [bbl_pkg::PIX_W-1:0]        byp_older_s1;
	logic [bbl_pkg::PIX_W-1:0]        byp_prior_s1;

	logic [bbl_pkg::PIX_W-1:0]        older_ram;
	logic [bbl_pkg::PIX_W-1:0]        prior_ram;
	logic [bbl_pkg::PIX_W-1:0]        older_rd;
	logic [bbl_pkg::PIX_W-1:0]        prior_rd;
	logic [bbl_pkg::PIX_W-1:0]        bottom;
	logic                             wr_en;
	logic [bbl_pkg::PIX_W-1:0]        older_wdata;
	bbl_pkg::csum_t                   col_sum;
	bbl_pkg::csum_t                   window_lft_q;
	bbl_pkg::csum_t                   window_ctr_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbl_pkg::WIDTH_RESET;
			height_q <= bbl_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bbl_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= cfg_data[bbl_pkg::WIDTH_REG_W-1:0];
				end
				bbl_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Frame size used clamped to the supported range.
	always_comb begin
		if (width_q == '0) begin
			width_eff = bbl_pkg::WIDTH_REG_W'(1);
		end else if (width_q > bbl_pkg::WIDTH_REG_W'(bbl_pkg::MAX_WIDTH)) begin
			width_eff = bbl_pkg::WIDTH_REG_W'(bbl_pkg::MAX_WIDTH);
		end else begin
			width_eff = width_q;
		end
		if (height_q == '0) begin
			height_eff = bbl_pkg::HEIGHT_REG_W'(1);
		end else if (height_q > bbl_pkg::HEIGHT_REG_W'(bbl_pkg::MAX_HEIGHT)) begin
			height_eff = bbl_pkg::HEIGHT_REG_W'(bbl_pkg::MAX_HEIGHT);
		end else begin
			height_eff = height_q;
		end
	end

	// Accept while the queue has room for everything already in flight.
	assign occupancy = {1'b0, fifo_stat.level} + {{bbl_pkg::FIFO_LVL_W{1'b0}}, valid_s1};
	assign in_ready  = occupancy < (bbl_pkg::FIFO_LVL_W + 1)'(bbl_pkg::FIFO_DEPTH);

	// A pixel during the drain or a drain tick outside it is dropped.
	assign take     = in_valid && in_ready && ((op == bbl_pkg::OP_DRAIN) == draining_q);
	assign end_row  = (bbl_pkg::WIDTH_REG_W'(column_count_q) + bbl_pkg::WIDTH_REG_W'(1))
		>= width_eff;
	assign last_row = (bbl_pkg::HEIGHT_REG_W'(row_count_q) + bbl_pkg::HEIGHT_REG_W'(1))
		>= height_eff;
	assign emitting = draining_q || (row_count_q != '0);

	// Raster position and drain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			draining_q     <= 1'b0;
		end else if (take) begin
			if (end_row) begin
				column_count_q <= '0;
				if (draining_q) begin
					draining_q  <= 1'b0;
					row_count_q <= '0;
				end else if (last_row) begin
					draining_q  <= 1'b1;
					row_count_q <= '0;
				end else begin
					row_count_q <= row_count_q + bbl_pkg::ROW_W'(1);
				end
			end else begin
				column_count_q <= column_count_q + bbl_pkg::COL_W'(1);
			end
		end
	end

	// Stage 1 control, with a bypass for a store write to the same column
	// in the cycle of the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			valid_s1 <= take;
			byp_s1   <= wr_en && (col_s1 == column_count_q);
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (take) begin
			drain_s1     <= draining_q;
			row0_s1      <= (row_count_q == '0);
			first_col_s1 <= (column_count_q == '0);
			has_a_s1     <= emitting && (column_count_q != '0);
			has_b_s1     <= emitting && end_row;
			eof_s1       <= draining_q && end_row;
			col_s1       <= column_count_q;
			pix_s1       <= {red_in, green_in, blue_in};
		end
		byp_older_s1 <= older_wdata;
		byp_prior_s1 <= pix_s1;
	end

	// Line stores: the row two above and the row just above.
	bbl_ram #(
		.WIDTH (bbl_pkg::PIX_W),
		.DEPTH (bbl_pkg::MAX_WIDTH)
	) u_older_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (older_wdata),
		.rd_addr (column_count_q),
		.rd_data (older_ram)
	);

	bbl_ram #(
		.WIDTH (bbl_pkg::PIX_W),
		.DEPTH (bbl_pkg::MAX_WIDTH)
	) u_prior_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_addr (column_count_q),
		.rd_data (prior_ram)
	);

	// Store update: the top row is replicated upward on the first row.
	assign older_rd    = byp_s1 ? byp_older_s1 : older_ram;
	assign prior_rd    = byp_s1 ? byp_prior_s1 : prior_ram;
	assign bottom      = drain_s1 ? prior_rd : pix_s1;
	assign wr_en       = valid_s1 && !drain_s1;
	assign older_wdata = row0_s1 ? pix_s1 : prior_rd;

	// Per-channel sum of the new column.
	always_comb begin
		for (int ch = 0; ch < bbl_pkg::NUM_CH; ch++) begin
			col_sum[ch] = bbl_pkg::CSUM_W'(older_rd[ch*bbl_pkg::CH_W +: bbl_pkg::CH_W])
				+ bbl_pkg::CSUM_W'(prior_rd[ch*bbl_pkg::CH_W +: bbl_pkg::CH_W])
				+ bbl_pkg::CSUM_W'(bottom[ch*bbl_pkg::CH_W +: bbl_pkg::CH_W]);
		end
	end

	// Window of column sums; the left edge is replicated at column zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_lft_q <= '0;
			window_ctr_q <= '0;
		end else if (valid_s1) begin
			window_lft_q <= first_col_s1 ? col_sum : window_ctr_q;
			window_ctr_q <= col_sum;
		end
	end

	// Window sums for the interior pixel and for the right-edge pixel.
	always_comb begin
		push_job.has_a = has_a_s1;
		push_job.has_b = has_b_s1;
		push_job.eof   = eof_s1;
		for (int ch = 0; ch < bbl_pkg::NUM_CH; ch++) begin
			push_job.sum_a[ch] = bbl_pkg::TSUM_W'(window_lft_q[ch])
				+ bbl_pkg::TSUM_W'(window_ctr_q[ch])
				+ bbl_pkg::TSUM_W'(col_sum[ch]);
			if (first_col_s1) begin
				push_job.sum_b[ch] = bbl_pkg::TSUM_W'(col_sum[ch])
					+ (bbl_pkg::TSUM_W'(col_sum[ch]) << 1);
			end else begin
				push_job.sum_b[ch] = bbl_pkg::TSUM_W'(window_ctr_q[ch])
					+ (bbl_pkg::TSUM_W'(col_sum[ch]) << 1);
			end
		end
	end

	assign push = valid_s1 && (has_a_s1 || has_b_s1);

`ifndef NO_ASSERTIONS
	// The drain pass always runs with the row counter cleared.
	a_drain_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> (row_count_q == '0))
		else $error("row counter not zero while draining");

	// The frame end is only flagged on a right-edge result.
	a_eof_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && eof_s1) |-> has_b_s1)
		else $error("frame end without a right-edge result");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bbl_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_fifo
// Short job queue that decouples the front part from the output side.
// ----------------------------------------------------------------------------
module bbl_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bbl_pkg::job_t push_job,
	input  wire logic          pop,
	output bbl_pkg::job_t      head_job,
	output bbl_pkg::fifo_stat_t stat
);

	bbl_pkg::job_t                   mem_q [bbl_pkg::FIFO_DEPTH];
	logic [bbl_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [bbl_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [bbl_pkg::FIFO_LVL_W-1:0]  level_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bbl_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bbl_pkg::FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + bbl_pkg::FIFO_LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - bbl_pkg::FIFO_LVL_W'(1);
			end
		end
	end

	assign head_job       = mem_q[rd_ptr_q];
	assign stat.level     = level_q;
	assign stat.not_empty = (level_q != '0);

`ifndef NO_ASSERTIONS
	// The front only pushes when an entry is free.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level_q < bbl_pkg::FIFO_LVL_W'(bbl_pkg::FIFO_DEPTH)))
		else $error("job queue overflow");

	// The back only pops a stored job.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (level_q != '0))
		else $error("job queue underflow");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bbl_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbl_back
// Takes queued jobs, divides each window sum by nine and presents one
// result per cycle, while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module bbl_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire bbl_pkg::fifo_stat_t      fifo_stat,
	input  wire bbl_pkg::job_t            head_job,
	output logic                          pop,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [bbl_pkg::CH_W-1:0]      blue_out,
	output logic [bbl_pkg::CH_W-1:0]      green_out,
	output logic [bbl_pkg::CH_W-1:0]      red_out,
	output logic                          last_of_run,
	output logic                          end_of_frame
);

	bbl_pkg::job_t job_q;
	logic          job_valid_q;
	logic          phase_q;
	logic          sel_b;
	logic          final_res;
	logic          load;
	logic          emit;
	logic          done;
	bbl_pkg::tsum_t cur_sum;

	// Floor of a nine-sample sum divided by nine, by reciprocal multiply.
	function automatic logic [bbl_pkg::CH_W-1:0] div9(input logic [bbl_pkg::TSUM_W-1:0] x);
		logic [bbl_pkg::TSUM_W+bbl_pkg::RECIP_W-1:0] prod;
		prod = (bbl_pkg::TSUM_W + bbl_pkg::RECIP_W)'(x)
			* (bbl_pkg::TSUM_W + bbl_pkg::RECIP_W)'(bbl_pkg::RECIP_9);
		return prod[bbl_pkg::RECIP_SHIFT +: bbl_pkg::CH_W];
	endfunction

	// Pick the interior result first, then the right-edge result.
	assign sel_b     = !job_q.has_a || phase_q;
	assign final_res = sel_b || !job_q.has_b;
	assign cur_sum   = sel_b ? job_q.sum_b : job_q.sum_a;
	assign load      = !out_valid || out_ready;
	assign emit      = job_valid_q && load;
	assign done      = emit && final_res;
	assign pop       = fifo_stat.not_empty && (!job_valid_q || done);

	// Current job control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (pop) begin
			job_valid_q <= 1'b1;
			phase_q     <= 1'b0;
		end else if (done) begin
			job_valid_q <= 1'b0;
		end else if (emit) begin
			phase_q <= 1'b1;
		end
	end

	// Current job payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			blue_out     <= div9(cur_sum[0]);
			green_out    <= div9(cur_sum[1]);
			red_out      <= div9(cur_sum[2]);
			last_of_run  <= final_res;
			end_of_frame <= sel_b && job_q.eof;
		end
	end

`ifndef NO_ASSERTIONS
	// The bottom-right pixel is always the final result of its request.
	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && end_of_frame) |-> last_of_run)
		else $error("frame end on a result that is not last of its request");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 3x3 box blur with edge replication
// Frames of random pixels, drain ticks and stray requests go through the
// valid/ready input port, with frame sizes changed between phases. The bench
// keeps its own copy of the line stores and the 3x3 window, and checks every
// output pixel, the last-of-run flag and the end-of-frame flag in order.
// ----------------------------------------------------------------------------
module tb_top;
	import bbl_pkg::*;

	localparam int unsigned RANDOM_ITEMS    = 1050;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned END_WAIT_CYCLES = 20000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned TIMEOUT_CYCLES  = 1000000;

	typedef logic [PIX_W-1:0] px_t;
	typedef logic [2:0][PIX_W-1:0] px_col_t;

	// One request as queued for the driver.
	typedef struct packed {
		logic op;
		px_t  pix;
	} blur_req_t;

	// One output pixel with its flags.
	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
		logic            last;
		logic            eof;
	} blur_px_t;

	// Clock, reset and the block's ports.
	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic                   op           = OP_PIXEL;
	logic [CH_W-1:0]        blue_in      = '0;
	logic [CH_W-1:0]        green_in     = '0;
	logic [CH_W-1:0]        red_in       = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic [CH_W-1:0]        blue_out;
	logic [CH_W-1:0]        green_out;
	logic [CH_W-1:0]        red_out;
	logic                   last_of_run;
	logic                   end_of_frame;
	logic                   cfg_wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index    = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;

	// Request traffic and the pixels still owed by the block.
	blur_req_t   pending_q [$];
	blur_px_t    blurred_q [$];
	blur_req_t   next_req;
	blur_px_t    want_px;
	int unsigned pushed_count   = 0;
	int unsigned accepted_count = 0;
	int unsigned useful_count   = 0;
	int unsigned fail_count     = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	bit          in_taken       = 1'b0;
	bit          result_taken   = 1'b0;
	bit          burst          = 1'b0;
	bit          hold_off       = 1'b0;
	bit          squeeze        = 1'b0;

	// Shadow of the block: registers, line stores, window and position.
	logic [WIDTH_REG_W-1:0]  cfg_width  = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] cfg_height = HEIGHT_RESET;
	bit [PIX_W-1:0]          older_row [MAX_WIDTH];
	bit [PIX_W-1:0]          prior_row [MAX_WIDTH];
	px_col_t                 win_left   = '0;
	px_col_t                 win_ctr    = '0;
	int unsigned             col_pos    = 0;
	int unsigned             row_pos    = 0;
	bit                      flushing   = 1'b0;

	box_blur_3x3_edge_replicate dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.blue_in      (blue_in),
		.green_in     (green_in),
		.red_in       (red_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.blue_out     (blue_out),
		.green_out    (green_out),
		.red_out      (red_out),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Frame size as the block uses it, clamped to the supported range.
	function automatic int unsigned eff_width();
		int unsigned v;
		v = cfg_width;
		if (v < 1) v = 1;
		if (v > MAX_WIDTH) v = MAX_WIDTH;
		return v;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned v;
		v = cfg_height;
		if (v < 1) v = 1;
		if (v > MAX_HEIGHT) v = MAX_HEIGHT;
		return v;
	endfunction

	// Per-channel floor of the nine-sample mean over three window columns.
	function automatic blur_px_t window_mean(input px_col_t a, input px_col_t b,
			input px_col_t c);
		blur_px_t    r;
		int unsigned s [3];
		int          ch;
		int          i;
		for (ch = 0; ch < NUM_CH; ch++) begin
			s[ch] = 0;
			for (i = 0; i < 3; i++) begin
				s[ch] += a[i][ch*CH_W +: CH_W] + b[i][ch*CH_W +: CH_W] + c[i][ch*CH_W +: CH_W];
			end
		end
		r.blue  = CH_W'(s[0] / 9);
		r.green = CH_W'(s[1] / 9);
		r.red   = CH_W'(s[2] / 9);
		r.last  = 1'b0;
		r.eof   = 1'b0;
		return r;
	endfunction

	// Advance the shadow by one accepted request and queue the pixels it owes.
	function automatic void predict_blur(input logic req_op, input px_t pix);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned n;
		int          k;
		px_col_t     col;
		logic        drain_tick;
		logic        emitting;
		logic        end_row;
		blur_px_t    res [2];
		w = eff_width();
		h = eff_height();
		drain_tick = (req_op == OP_DRAIN);
		// A pixel while draining and a drain tick mid-frame are both dropped.
		if (drain_tick != flushing) return;
		useful_count++;
		c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
		col[0] = older_row[c];
		col[1] = prior_row[c];
		col[2] = drain_tick ? col[1] : pix;
		if (!drain_tick) begin
			older_row[c] = (row_pos == 0) ? pix : col[1];
			prior_row[c] = pix;
		end
		emitting = flushing || (row_pos != 0);
		end_row = (c + 1 >= w);
		n = 0;
		// The left edge replicates its own column; later columns slide the window.
		if (c == 0) begin
			win_left = col;
			win_ctr = col;
		end else begin
			if (emitting) begin
				res[n] = window_mean(win_left, win_ctr, col);
				n++;
			end
			win_left = win_ctr;
			win_ctr = col;
		end
		// The pixel that closes a row also gives the right-edge output.
		if (end_row && emitting) begin
			res[n] = window_mean(win_left, win_ctr, win_ctr);
			n++;
		end
		if (n > 0) res[n-1].last = 1'b1;
		if (end_row) begin
			col_pos = 0;
			if (flushing) begin
				if (n > 0) res[n-1].eof = 1'b1;
				flushing = 1'b0;
				row_pos = 0;
			end else if (row_pos + 1 >= h) begin
				flushing = 1'b1;
				row_pos = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos = c + 1;
		end
		for (k = 0; k < n; k++) blurred_q.push_back(res[k]);
	endfunction

	// Wait for one side, drawn per request; none during a burst phase.
	function automatic int unsigned draw_wait();
		if (burst) return 0;
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 17);
	endfunction

	// Sample value with the extremes drawn more often than chance.
	function automatic logic [CH_W-1:0] rand_sample();
		if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
		return CH_W'($urandom_range(0, 255));
	endfunction

	function automatic px_t rand_pixel();
		return {rand_sample(), rand_sample(), rand_sample()};
	endfunction

	function automatic bit pipeline_idle();
		return pending_q.size() == 0 && accepted_count == pushed_count &&
			blurred_q.size() == 0;
	endfunction

	task automatic push_req(input logic req_op, input px_t pix);
		blur_req_t r;
		r.op = req_op;
		r.pix = pix;
		pending_q.push_back(r);
		pushed_count++;
	endtask

	// Register write; the shadow copy follows at once since the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		if (idx == CFG_IMAGE_WIDTH) cfg_width = value[WIDTH_REG_W-1:0];
		else cfg_height = value[HEIGHT_REG_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Let all requests and owed pixels pass, then settle so dropped ones clear.
	task automatic wait_idle();
		while (!pipeline_idle()) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One whole frame from its start, with a stray request now and then.
	task automatic send_frame();
		int unsigned w;
		int unsigned h;
		w = eff_width();
		h = eff_height();
		repeat (w * h) begin
			if ($urandom_range(0, 15) == 0) push_req(OP_DRAIN, rand_pixel());
			push_req(OP_PIXEL, rand_pixel());
		end
		repeat (w) begin
			if ($urandom_range(0, 15) == 0) push_req(OP_PIXEL, rand_pixel());
			push_req(OP_DRAIN, rand_pixel());
		end
	endtask

	// Complete whatever frame is open; the shadow must be up to date.
	task automatic finish_frame();
		int unsigned w;
		int unsigned h;
		int unsigned n_pix;
		int unsigned n_drain;
		w = eff_width();
		h = eff_height();
		n_pix = 0;
		n_drain = w;
		if (flushing) begin
			n_drain = (col_pos >= w) ? 1 : w - col_pos;
		end else if (col_pos != 0 || row_pos != 0) begin
			n_pix = (col_pos >= w) ? 1 : w - col_pos;
			if (row_pos + 1 < h) n_pix += (h - row_pos - 1) * w;
		end else begin
			n_drain = 0;
		end
		repeat (n_pix) push_req(OP_PIXEL, rand_pixel());
		repeat (n_drain) push_req(OP_DRAIN, rand_pixel());
	endtask

	// Accepted requests feed the shadow model.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			predict_blur(op, {red_in, green_in, blue_in});
			accepted_count++;
			in_taken = 1'b1;
		end
	end

	// Request driver: holds a request until taken, then waits its drawn gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_taken) begin
				in_taken = 1'b0;
				gap_left = draw_wait();
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				next_req = pending_q.pop_front();
				in_valid <= 1'b1;
				op <= next_req.op;
				blue_in <= next_req.pix[7:0];
				green_in <= next_req.pix[15:8];
				red_in <= next_req.pix[23:16];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [CH_W-1:0] want_v,
			input logic [CH_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Output checker: every accepted pixel against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (blurred_q.size() == 0) begin
				$error("output pixel with none owed: blue %0d green %0d red %0d",
					blue_out, green_out, red_out);
				fail_count++;
			end else begin
				want_px = blurred_q.pop_front();
				check_field("blue_out", want_px.blue, blue_out);
				check_field("green_out", want_px.green, green_out);
				check_field("red_out", want_px.red, red_out);
				check_field("last_of_run", CH_W'(want_px.last), CH_W'(last_of_run));
				check_field("end_of_frame", CH_W'(want_px.eof), CH_W'(end_of_frame));
			end
			result_taken = 1'b1;
		end
	end

	// Receiver: stalls for a drawn wait after each pixel it takes.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (result_taken) begin
				result_taken = 1'b0;
				stall_left = draw_wait();
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long receiver stall during a drain pass, so the queue fills and the
	// input backs up while requests keep coming.
	initial begin
		wait (squeeze);
		hold_off = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Overall time limit.
	initial begin
		repeat (TIMEOUT_CYCLES) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: directed corner cases, then random phases of frames.
	initial begin : stimulus
		int unsigned phase_no;
		int unsigned target;
		int unsigned n;
		phase_no = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Small frame with extreme samples, a stray drain tick mid-frame
		// and a stray pixel during the drain.
		write_reg(CFG_IMAGE_WIDTH, 3);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		push_req(OP_PIXEL, 24'h000000);
		push_req(OP_DRAIN, 24'hFFFFFF);
		push_req(OP_PIXEL, 24'hFFFFFF);
		push_req(OP_PIXEL, 24'h00FF00);
		push_req(OP_PIXEL, 24'hFF00FF);
		push_req(OP_PIXEL, 24'h000000);
		push_req(OP_PIXEL, 24'hFFFFFF);
		push_req(OP_DRAIN, 24'h000000);
		push_req(OP_PIXEL, 24'h123456);
		push_req(OP_DRAIN, 24'hFFFFFF);
		push_req(OP_DRAIN, 24'h000000);
		wait_idle();

		// Zero width and height clamp to a single-pixel frame.
		write_reg(CFG_IMAGE_WIDTH, 0);
		write_reg(CFG_IMAGE_HEIGHT, 0);
		push_req(OP_PIXEL, 24'hFF00FF);
		push_req(OP_DRAIN, 24'h00FF00);
		wait_idle();

		// Width shrunk mid-row: the next pixel closes the row.
		write_reg(CFG_IMAGE_WIDTH, 5);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		repeat (8) push_req(OP_PIXEL, rand_pixel());
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, 2);
		push_req(OP_PIXEL, rand_pixel());
		push_req(OP_DRAIN, rand_pixel());
		push_req(OP_DRAIN, rand_pixel());
		wait_idle();

		target = useful_count + RANDOM_ITEMS;
		while (useful_count < target) begin
			phase_no++;
			wait_idle();
			// Close an open frame, sometimes after shrinking it first.
			if (col_pos != 0 || row_pos != 0 || flushing) begin
				if ($urandom_range(0, 2) == 0) begin
					write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, eff_width()));
					if ($urandom_range(0, 1) == 0) write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 6));
				end
				finish_frame();
				wait_idle();
			end
			burst = (phase_no % 5 == 3);
			if (phase_no == 1) begin
				// Tallest setting, cut short by a zero height once a few rows are in.
				write_reg(CFG_IMAGE_WIDTH, 3);
				write_reg(CFG_IMAGE_HEIGHT, 8191);
				repeat (15) push_req(OP_PIXEL, rand_pixel());
				wait_idle();
				write_reg(CFG_IMAGE_HEIGHT, 0);
			end else if (phase_no == 2) begin
				// Width past the limit clamps to the widest row. The drain pass then
				// runs narrow while the receiver holds off.
				write_reg(CFG_IMAGE_WIDTH, 2047);
				write_reg(CFG_IMAGE_HEIGHT, 1);
				repeat (MAX_WIDTH) push_req(OP_PIXEL, rand_pixel());
				wait_idle();
				write_reg(CFG_IMAGE_WIDTH, 16);
				squeeze = 1'b1;
				repeat (16) push_req(OP_DRAIN, rand_pixel());
			end else begin
				if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_WIDTH, $urandom_range(0, 12));
				if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_HEIGHT, $urandom_range(0, 6));
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(4, 30)) begin
						push_req(($urandom_range(0, 1) == 0) ? OP_PIXEL : OP_DRAIN, rand_pixel());
					end
				end else begin
					repeat ($urandom_range(1, 2)) send_frame();
				end
			end
		end
		burst = 1'b0;
		wait_idle();
		finish_frame();

		// Let the last pixels come out, then settle.
		n = 0;
		while (!pipeline_idle() && n < END_WAIT_CYCLES) begin
			@(posedge clk);
			n++;
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (!pipeline_idle()) begin
			$error("%0d output pixels and %0d requests still outstanding",
				blurred_q.size(), pushed_count - accepted_count);
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
